[rtl/pwos_pkg.sv]
`default_nettype none

package pwos_pkg;

    // Phase values are unsigned Q4.32 radians below two pi
    localparam int PH_W = 36;
    // CORDIC angle register, signed Q5.32
    localparam int Z_W  = 37;
    // CORDIC x/y, signed Q2.30 with headroom
    localparam int XY_W = 34;
    // Coefficient width, signed Q1.30
    localparam int CF_W = 31;
    // Result width, signed Q10.30
    localparam int OUT_W = 40;

    localparam logic [PH_W-1:0] TWO_PI_Q  = 36'd26986075409;
    localparam logic [PH_W-1:0] PI_Q      = 36'd13493037704;
    localparam logic [PH_W-1:0] HALF_PI_Q = 36'd6746518852;
    localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic [OUT_W-1:0] OUT_MAX = 40'd549755813887;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_K_X     = 3'd0,
        REG_K_Y     = 3'd1,
        REG_K_Z     = 3'd2,
        REG_PW_NORM = 3'd3,
        REG_G_COUNT = 3'd4
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PH_INIT,
        ST_PH_BIT,
        ST_PH_END,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_MUL,
        ST_SCALE,
        ST_DONE
    } state_t;

    // atan(2^-i) in unsigned Q1.32
    function automatic logic [32:0] pwos_atan(input logic [4:0] idx);
        logic [32:0] v;
        case (idx)
            5'd0:  v = 33'd3373259426;
            5'd1:  v = 33'd1991351318;
            5'd2:  v = 33'd1052175346;
            5'd3:  v = 33'd534100635;
            5'd4:  v = 33'd268086748;
            5'd5:  v = 33'd134174063;
            5'd6:  v = 33'd67103403;
            5'd7:  v = 33'd33553749;
            5'd8:  v = 33'd16777131;
            5'd9:  v = 33'd8388597;
            5'd10: v = 33'd4194303;
            5'd11: v = 33'd2097152;
            5'd12: v = 33'd1048576;
            5'd13: v = 33'd524288;
            5'd14: v = 33'd262144;
            5'd15: v = 33'd131072;
            5'd16: v = 33'd65536;
            5'd17: v = 33'd32768;
            5'd18: v = 33'd16384;
            5'd19: v = 33'd8192;
            5'd20: v = 33'd4096;
            5'd21: v = 33'd2048;
            5'd22: v = 33'd1024;
            5'd23: v = 33'd512;
            5'd24: v = 33'd256;
            5'd25: v = 33'd128;
            5'd26: v = 33'd64;
            5'd27: v = 33'd32;
            5'd28: v = 33'd16;
            5'd29: v = 33'd8;
            5'd30: v = 33'd4;
            default: v = 33'd2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/pwos_cordic.sv]
`default_nettype none

module pwos_cordic #(
    parameter int STEPS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [pwos_pkg::PH_W-1:0]         theta,
    output logic                                   done,
    output logic signed [pwos_pkg::XY_W-1:0]       cos_o,
    output logic signed [pwos_pkg::XY_W-1:0]       sin_o
);
    import pwos_pkg::*;

    localparam int IT_W = $clog2(STEPS + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   flip_reg, flip_next;
    logic [IT_W-1:0]        it_reg, it_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;

    logic signed [Z_W-1:0]  z0, z1;
    logic                   f1;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;

    // Quadrant fold of the reduced phase
    always_comb begin
        z0 = $signed({1'b0, theta});
        if (theta >= PI_Q) begin
            z0 = z0 - $signed({1'b0, TWO_PI_Q});
        end
        z1 = z0;
        f1 = 1'b0;
        if (z0 > $signed({1'b0, HALF_PI_Q})) begin
            z1 = z0 - $signed({1'b0, PI_Q});
            f1 = 1'b1;
        end else if (z0 < -$signed({1'b0, HALF_PI_Q})) begin
            z1 = z0 + $signed({1'b0, PI_Q});
            f1 = 1'b1;
        end
    end

    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign at = $signed({4'b0, pwos_atan(5'(it_reg))});

    // One micro-rotation per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        flip_next = flip_reg;
        it_next   = it_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            it_next   = '0;
            x_next    = CORDIC_K;
            y_next    = '0;
            z_next    = z1;
            flip_next = f1;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        flip_reg <= flip_next;
        it_reg   <= it_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done  = done_reg;
    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

[rtl/plane_wave_orbital_sum.sv]
// Load item: written in the cycle it is accepted, next item accepted in the cycle after.
// Evaluate item: for n vectors in use, input is ready again in the same cycle
// that the result appears;
// each vector takes three bit-serial phase products on one modular
// adder, one CORDIC pass and the complex multiply on one shared multiplier.
// Synchronous active-low reset clears control state; the tables are undefined.
`default_nettype none

module plane_wave_orbital_sum #(
    parameter int MAX_G        = 1024,
    parameter int MAX_BANDS    = 8,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // tdata: entry_index[9:0] band[12:10] g_x[44:13] g_y[76:45] g_z[108:77]
    //        coef_re[139:109] coef_im[170:140] pos_x[202:171] pos_y[234:203]
    //        pos_z[266:235], zero pad
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [271:0] s_tdata,
    // tuser: kind[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: value_re[39:0] value_im[79:40]
    output logic [79:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import pwos_pkg::*;

    localparam int GI_W  = (MAX_G > 1) ? $clog2(MAX_G) : 1;
    localparam int CDEP  = MAX_BANDS * MAX_G;
    localparam int CA_W  = (CDEP > 1) ? $clog2(CDEP) : 1;
    localparam int N_W   = $clog2(MAX_G + 1);
    localparam int ACC_W = 34 + N_W;
    localparam int HI_W  = ACC_W - 30;
    localparam logic signed [65:0] RND = 66'sd536870912;

    // Input fields
    logic        in_kind;
    logic [9:0]  in_entry;
    logic [2:0]  in_band;
    logic [95:0] in_g;
    logic [61:0] in_coef;
    logic [95:0] in_pos;
    assign in_kind  = s_tuser[0];
    assign in_entry = s_tdata[9:0];
    assign in_band  = s_tdata[12:10];
    assign in_g     = s_tdata[108:13];
    assign in_coef  = s_tdata[170:109];
    assign in_pos   = s_tdata[266:171];

    // Configuration registers
    logic signed [31:0] kx_reg, ky_reg, kz_reg;
    logic [29:0]        pw_reg;
    logic [10:0]        gcnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kx_reg   <= '0;
            ky_reg   <= '0;
            kz_reg   <= '0;
            pw_reg   <= 30'h3FFFFFFF;
            gcnt_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_K_X:     kx_reg   <= cfg_data;
                REG_K_Y:     ky_reg   <= cfg_data;
                REG_K_Z:     kz_reg   <= cfg_data;
                REG_PW_NORM: pw_reg   <= cfg_data[29:0];
                REG_G_COUNT: gcnt_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [N_W-1:0]      g_reg, g_next, n_reg, n_next;
    logic [CA_W-1:0]     base_reg, base_next;
    logic [95:0]         pos_reg, pos_next;
    logic [1:0]          comp_reg, comp_next;
    logic [5:0]          bit_reg, bit_next;
    logic [31:0]         ma_reg, ma_next;
    logic [32:0]         mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic [PH_W-1:0]     pacc_reg, pacc_next, th_reg, th_next;
    logic [2:0]          step_reg, step_next;
    logic                sel_reg, sel_next;
    logic signed [64:0]  prod_reg, prod_next;
    logic signed [65:0]  part_reg, part_next;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic [ACC_W-1:0]    mag_reg, mag_next;
    logic                sneg_reg, sneg_next;
    logic [OUT_W-1:0]    res_re_reg, res_re_next, res_im_reg, res_im_next;
    logic                ov_reg, ov_next;
    logic [79:0]         out_reg, out_next;

    // Tables
    logic [95:0] gmem [MAX_G];
    logic [61:0] cmem [CDEP];
    logic [95:0] gv_q;
    logic [61:0] cf_q;

    logic            load_we;
    logic [GI_W-1:0] w_gidx;
    logic [CA_W-1:0] w_caddr;
    logic [CA_W-1:0] r_caddr;

    assign load_we = s_tvalid && s_tready && (in_kind == KIND_LOAD)
                     && (32'(in_entry) < 32'(MAX_G)) && (32'(in_band) < 32'(MAX_BANDS));
    assign w_gidx  = GI_W'(in_entry);
    assign w_caddr = CA_W'(32'(in_band) * 32'(MAX_G) + 32'(in_entry));
    assign r_caddr = base_reg + CA_W'(g_reg);

    always_ff @(posedge aclk) begin
        if (load_we) begin
            gmem[w_gidx]  <= in_g;
            cmem[w_caddr] <= in_coef;
        end
        gv_q <= gmem[GI_W'(g_reg)];
        cf_q <= cmem[r_caddr];
    end

    // Shared CORDIC
    logic                   cord_start, cord_done;
    logic signed [XY_W-1:0] cos_w, sin_w;

    pwos_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .theta   (th_reg),
        .done    (cord_done),
        .cos_o   (cos_w),
        .sin_o   (sin_w)
    );

    // Component select for the phase products
    logic signed [31:0] g_sel, k_sel, p_sel;
    logic signed [32:0] s_sum;
    logic [32:0]        s_abs;
    logic [31:0]        p_abs;

    always_comb begin
        case (comp_reg)
            2'd0:    begin g_sel = gv_q[31:0];  k_sel = kx_reg; p_sel = pos_reg[31:0];  end
            2'd1:    begin g_sel = gv_q[63:32]; k_sel = ky_reg; p_sel = pos_reg[63:32]; end
            default: begin g_sel = gv_q[95:64]; k_sel = kz_reg; p_sel = pos_reg[95:64]; end
        endcase
    end

    assign s_sum = {g_sel[31], g_sel} + {k_sel[31], k_sel};
    assign s_abs = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);
    assign p_abs = p_sel[31] ? 32'(-p_sel) : 32'(p_sel);

    // Modular double-and-add, one multiplier bit per cycle
    logic [PH_W-1:0] dbl, d1, d2, d3;
    assign dbl = {pacc_reg[PH_W-2:0], 1'b0};
    assign d1  = (dbl >= TWO_PI_Q) ? dbl - TWO_PI_Q : dbl;
    assign d2  = d1 + PH_W'(ma_reg);
    assign d3  = mb_reg[bit_reg] ? ((d2 >= TWO_PI_Q) ? d2 - TWO_PI_Q : d2) : d1;

    // Phase term sign fix and running phase sum
    logic [PH_W-1:0] term, tsum;
    assign term = (neg_reg && (pacc_reg != '0)) ? TWO_PI_Q - pacc_reg : pacc_reg;
    assign tsum = th_reg + term;

    // Shared multiplier
    logic signed [XY_W-1:0] mul_a;
    logic signed [CF_W-1:0] mul_b;
    logic signed [CF_W-1:0] cr, cim;
    assign cr  = cf_q[30:0];
    assign cim = cf_q[61:31];

    always_comb begin
        mul_a = cos_w;
        mul_b = cr;
        if (state_reg == ST_SCALE) begin
            mul_b = $signed({1'b0, pw_reg});
            if (step_reg == 3'd1) begin
                mul_a = $signed({4'b0, mag_reg[29:0]});
            end else begin
                mul_a = $signed({{(XY_W - HI_W){1'b0}}, mag_reg[ACC_W-1:30]});
            end
        end else begin
            case (step_reg)
                3'd0:    begin mul_a = cos_w; mul_b = cr;  end
                3'd1:    begin mul_a = sin_w; mul_b = cim; end
                3'd2:    begin mul_a = cos_w; mul_b = cim; end
                default: begin mul_a = sin_w; mul_b = cr;  end
            endcase
        end
    end

    // Scaling helpers
    logic signed [ACC_W-1:0] acc_sel;
    logic signed [65:0]      r_sum;
    logic [OUT_W-1:0]        r_sat, r_fin;
    assign acc_sel = sel_reg ? acc_im_reg : acc_re_reg;
    assign r_sum   = (part_reg >>> 30) + 66'(prod_reg);
    always_comb begin
        if (r_sum > $signed(66'(OUT_MAX))) begin
            r_sat = sneg_reg ? OUT_MAX + 1'b1 : OUT_MAX;
        end else begin
            r_sat = r_sum[OUT_W-1:0];
        end
        r_fin = sneg_reg ? -r_sat : r_sat;
    end

    logic [N_W-1:0] g_lim;
    assign g_lim = (32'(gcnt_reg) > 32'(MAX_G)) ? N_W'(MAX_G) : N_W'(gcnt_reg);

    // Next state and datapath
    always_comb begin
        state_next  = state_reg;
        g_next      = g_reg;
        n_next      = n_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        comp_next   = comp_reg;
        bit_next    = bit_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        pacc_next   = pacc_reg;
        th_next     = th_reg;
        step_next   = step_reg;
        sel_next    = sel_reg;
        prod_next   = mul_a * mul_b;
        part_next   = part_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        mag_next    = mag_reg;
        sneg_next   = sneg_reg;
        res_re_next = res_re_reg;
        res_im_next = res_im_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        cord_start  = 1'b0;
        s_tready    = 1'b0;

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (in_kind == KIND_EVAL)) begin
                    pos_next    = in_pos;
                    base_next   = CA_W'(32'(in_band) * 32'(MAX_G));
                    g_next      = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    step_next   = '0;
                    sel_next    = 1'b0;
                    if (32'(in_band) < 32'(MAX_BANDS)) begin
                        n_next = g_lim;
                    end else begin
                        n_next = '0;
                    end
                    if ((32'(in_band) < 32'(MAX_BANDS)) && (g_lim != '0)) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_FETCH: begin
                th_next    = '0;
                comp_next  = '0;
                state_next = ST_PH_INIT;
            end
            ST_PH_INIT: begin
                ma_next    = p_abs;
                mb_next    = s_abs;
                neg_next   = p_sel[31] ^ s_sum[32];
                pacc_next  = '0;
                bit_next   = 6'd32;
                state_next = ST_PH_BIT;
            end
            ST_PH_BIT: begin
                pacc_next = d3;
                if (bit_reg == '0) begin
                    state_next = ST_PH_END;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_PH_END: begin
                th_next = (tsum >= TWO_PI_Q) ? tsum - TWO_PI_Q : tsum;
                if (comp_reg == 2'd2) begin
                    state_next = ST_ROT_GO;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_PH_INIT;
                end
            end
            ST_ROT_GO: begin
                cord_start = 1'b1;
                state_next = ST_ROT_WAIT;
            end
            ST_ROT_WAIT: begin
                if (cord_done) begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd1: part_next = 66'(prod_reg) + RND;
                    3'd2: part_next = part_reg - 66'(prod_reg);
                    3'd3: begin
                        acc_re_next = acc_re_reg + ACC_W'(part_reg >>> 30);
                        part_next   = 66'(prod_reg) + RND;
                    end
                    3'd4: part_next = part_reg + 66'(prod_reg);
                    3'd5: begin
                        acc_im_next = acc_im_reg + ACC_W'(part_reg >>> 30);
                        step_next   = '0;
                        g_next      = g_reg + 1'b1;
                        if (g_reg + 1'b1 == n_reg) begin
                            sel_next   = 1'b0;
                            state_next = ST_SCALE;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCALE: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd0: begin
                        mag_next  = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
                        sneg_next = acc_sel[ACC_W-1];
                    end
                    3'd2: part_next = 66'(prod_reg) + RND;
                    3'd3: begin
                        step_next = '0;
                        if (sel_reg) begin
                            res_im_next = r_fin;
                            state_next  = ST_DONE;
                        end else begin
                            res_re_next = r_fin;
                            sel_next    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    out_next   = {res_im_reg, res_re_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            g_reg     <= '0;
            n_reg     <= '0;
            comp_reg  <= '0;
            bit_reg   <= '0;
            step_reg  <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            g_reg     <= g_next;
            n_reg     <= n_next;
            comp_reg  <= comp_next;
            bit_reg   <= bit_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
        base_reg   <= base_next;
        pos_reg    <= pos_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        pacc_reg   <= pacc_next;
        th_reg     <= th_next;
        prod_reg   <= prod_next;
        part_reg   <= part_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        mag_reg    <= mag_next;
        sneg_reg   <= sneg_next;
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // Modular accumulator stays reduced while bits are shifted in
    a_pacc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PH_BIT) |-> (pacc_reg < TWO_PI_Q))
        else $error("phase accumulator out of range");

    // Table walk never passes the count in use
    a_fetch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (g_reg < n_reg))
        else $error("fetch beyond vector count");

    // Rotation results only arrive while the sequencer waits for them
    a_cordic_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cord_done |-> (state_reg == ST_ROT_WAIT))
        else $error("unexpected rotation done");
`endif

endmodule

`default_nettype wire
